// ===== rtl/asymmetric_triangle_wave_generator_unit_assert.svh =====
// Assertion macros used by the generator RTL.
// Both macros expect clk_i and rst_ni in scope.
`ifndef ASYMMETRIC_TRIANGLE_WAVE_GENERATOR_UNIT_ASSERT_SVH
`define ASYMMETRIC_TRIANGLE_WAVE_GENERATOR_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define ATWG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ATWG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/atwg_pkg.sv =====
`default_nettype none

package atwg_pkg;

  // field widths
  localparam int AMP_W      = 12;
  localparam int WEIGHT_W   = 7;
  localparam int RELOAD_W   = 16;
  localparam int SAMPLE_W   = 12;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // shared divider sizing (covers point counts up to 4096)
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // front/back queue depth
  localparam int QUEUE_DEPTH = 2;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE   = 2'd0,
    REG_RISE_WEIGHT = 2'd1,
    REG_FALL_WEIGHT = 2'd2,
    REG_TICK_RELOAD = 2'd3
  } cfg_reg_e;

  // register reset values
  localparam logic [AMP_W-1:0]    AMPLITUDE_RST   = 12'd4095;
  localparam logic [WEIGHT_W-1:0] RISE_WEIGHT_RST = 7'd30;
  localparam logic [WEIGHT_W-1:0] FALL_WEIGHT_RST = 7'd30;
  localparam logic [RELOAD_W-1:0] TICK_RELOAD_RST = 16'd362;

  typedef struct packed {
    logic [AMP_W-1:0]    amplitude;
    logic [WEIGHT_W-1:0] rise_weight;
    logic [WEIGHT_W-1:0] fall_weight;
    logic [RELOAD_W-1:0] tick_reload;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EDGE,
    B_MUL,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/atwg_if.sv =====
`default_nettype none

// tick channel
interface atwg_in_if import atwg_pkg::*; ();
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// sample channel
interface atwg_out_if import atwg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [INDEX_W-1:0]  point_index;
  logic                cycle_end;

  modport source (output valid, output sample, output point_index, output cycle_end,
                  input ready);
  modport sink   (input valid, input sample, input point_index, input cycle_end,
                  output ready);
endinterface

// register write channel
interface atwg_cfg_if import atwg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/asymmetric_triangle_wave_generator_unit.sv =====
`default_nettype none

// Asymmetric triangle wave generator. Each item on in_i with tick set is one
// tick; every tick_reload+1 ticks one sample item leaves on out_o with the DAC
// code, the phase index and a flag on the last point of the period. Ticks are
// taken one per cycle while the two-entry queue between the tick counter and
// the sample engine has room. In the engine each sample runs through the queue
// pop, two 24-step divisions (rise end, then segment slope) in one shared
// restoring divider with a quotient handoff after each, the multiply between
// them and the output load. With tick_reload of 52 or more and the sample
// channel ready, the tick channel never stalls; shorter reloads or a held-off
// sample channel back-pressure it. Register writes apply to the next sample
// and do not reset the phase; write them only while no sample is in flight.
module asymmetric_triangle_wave_generator_unit import atwg_pkg::*; #(
  parameter int TablePoints = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  atwg_cfg_if.sink  cfg_i,
  atwg_in_if.sink   in_i,
  atwg_out_if.source out_o
);

  localparam int PW = $clog2(TablePoints);

  cfg_t          cfg_q;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [PW-1:0] front_phase;
  logic [PW-1:0] q_phase;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplitude   <= AMPLITUDE_RST;
      cfg_q.rise_weight <= RISE_WEIGHT_RST;
      cfg_q.fall_weight <= FALL_WEIGHT_RST;
      cfg_q.tick_reload <= TICK_RELOAD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_AMPLITUDE:   cfg_q.amplitude   <= cfg_i.data[AMP_W-1:0];
        REG_RISE_WEIGHT: cfg_q.rise_weight <= cfg_i.data[WEIGHT_W-1:0];
        REG_FALL_WEIGHT: cfg_q.fall_weight <= cfg_i.data[WEIGHT_W-1:0];
        REG_TICK_RELOAD: cfg_q.tick_reload <= cfg_i.data[RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  atwg_front #(
    .TablePoints (TablePoints)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .phase_o (front_phase)
  );

  atwg_queue #(
    .W (PW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_phase),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_phase)
  );

  atwg_back #(
    .TablePoints (TablePoints)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_phase),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/atwg_front.sv =====
`default_nettype none

module atwg_front import atwg_pkg::*; #(
  parameter int TablePoints = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfg_t                           cfg_i,
  atwg_in_if.sink                             in_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output logic [$clog2(TablePoints)-1:0]      phase_o
);

  localparam int PW = $clog2(TablePoints);
  localparam logic [PW-1:0] LastPoint = PW'(TablePoints - 1);

  logic [RELOAD_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]       phase_q, phase_d;
  logic                accept;
  logic                fire;

  // ticks are taken whenever the queue can hold an emission
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready && in_i.tick;
  assign fire       = accept && (cnt_q >= cfg_i.tick_reload);

  // reload counter and phase
  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (accept) begin
      if (fire) begin
        cnt_d   = '0;
        phase_d = (phase_q == LastPoint) ? '0 : phase_q + 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  assign push_o  = fire;
  assign phase_o = phase_q;

endmodule

`default_nettype wire

// ===== rtl/atwg_queue.sv =====
`default_nettype none

module atwg_queue import atwg_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LastSlot = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] Depth    = CNT_W'(QUEUE_DEPTH);

  logic [W-1:0]     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastSlot) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastSlot) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == Depth);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

// ===== rtl/atwg_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module atwg_div import atwg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_res_t      res_o
);

  localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W:0]   rem_s;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // one shift-subtract step
  assign rem_s = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge    = (rem_s >= {1'b0, den_q});
  assign diff  = rem_s - {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= LastStep;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : rem_s[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;

endmodule

`default_nettype wire

// ===== rtl/atwg_back.sv =====
`default_nettype none

`include "asymmetric_triangle_wave_generator_unit_assert.svh"

module atwg_back import atwg_pkg::*; #(
  parameter int TablePoints = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfg_t                           cfg_i,
  input  wire logic                           q_valid_i,
  input  wire logic [$clog2(TablePoints)-1:0] q_data_i,
  output logic                                q_pop_o,
  atwg_out_if.source                          out_o
);

  localparam int PW = $clog2(TablePoints);
  localparam logic [PW-1:0]        LastPoint = PW'(TablePoints - 1);
  localparam logic [PW:0]          PtsFull   = (PW + 1)'(TablePoints);
  localparam logic [DIV_NUM_W-1:0] PtsNum    = DIV_NUM_W'(TablePoints);

  back_state_e state_q, state_d;

  logic [PW-1:0]       pos_q;
  logic [PW-1:0]       edge_q;
  logic                rising_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic                out_end_q;

  div_req_t div_req;
  div_res_t div_res;

  logic [WEIGHT_W:0]    total;
  logic [PW-1:0]        edge_clamp;
  logic                 rising;
  logic [PW-1:0]        term;
  logic [DIV_NUM_W-1:0] edge_num;
  logic [DIV_NUM_W-1:0] mul_num;
  logic [DIV_DEN_W-1:0] mul_den;
  logic [SAMPLE_W-1:0]  quot_s;
  logic                 out_free;
  logic                 ld_edge, ld_mul, ld_sample, ld_out;

  atwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // rise end: points*rise/(rise+fall), clamped to 1..points-1
  assign total    = {1'b0, cfg_i.rise_weight} + {1'b0, cfg_i.fall_weight};
  assign edge_num = PtsNum * DIV_NUM_W'(cfg_i.rise_weight);

  always_comb begin
    if (total == '0 || div_res.quot == '0) begin
      edge_clamp = PW'(1);
    end else if (div_res.quot >= PtsNum) begin
      edge_clamp = LastPoint;
    end else begin
      edge_clamp = div_res.quot[PW-1:0];
    end
  end

  // segment product and divisor
  assign rising  = (pos_q < edge_q);
  assign term    = rising ? pos_q : pos_q - edge_q;
  assign mul_num = DIV_NUM_W'(cfg_i.amplitude) * DIV_NUM_W'(term);
  assign mul_den = rising ? DIV_DEN_W'(edge_q) : DIV_DEN_W'(PtsFull - {1'b0, edge_q});
  assign quot_s  = div_res.quot[SAMPLE_W-1:0];

  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (q_valid_i) state_d = B_EDGE;
      B_EDGE: if (div_res.done) state_d = B_MUL;
      B_MUL:  state_d = B_DIV;
      B_DIV:  if (div_res.done) state_d = B_OUT;
      B_OUT:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop_o       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = edge_num;
    div_req.den   = DIV_DEN_W'(total);
    ld_edge       = 1'b0;
    ld_mul        = 1'b0;
    ld_sample     = 1'b0;
    ld_out        = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        q_pop_o       = q_valid_i;
        div_req.start = q_valid_i;
      end
      B_EDGE: ld_edge = div_res.done;
      B_MUL: begin
        ld_mul        = 1'b1;
        div_req.start = 1'b1;
        div_req.num   = mul_num;
        div_req.den   = mul_den;
      end
      B_DIV: ld_sample = div_res.done;
      B_OUT: ld_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pos_q <= q_data_i;
    end
    if (ld_edge) begin
      edge_q <= edge_clamp;
    end
    if (ld_mul) begin
      rising_q <= rising;
    end
    if (ld_sample) begin
      sample_q <= rising_q ? quot_s : cfg_i.amplitude - quot_s;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_sample_q <= sample_q;
      out_index_q  <= INDEX_W'(pos_q);
      out_end_q    <= (pos_q == LastPoint);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample      = out_sample_q;
  assign out_o.point_index = out_index_q;
  assign out_o.cycle_end   = out_end_q;

  `ATWG_ASSERT_NEVER(a_div_done_unexpected,
    div_res.done && !(state_q == B_EDGE || state_q == B_DIV), "divider done while not waiting")
  `ATWG_ASSERT(a_edge_nonzero, (state_q == B_MUL) |-> (edge_q != '0), "rise end is zero")
  `ATWG_ASSERT(a_sample_le_amp, ld_out |-> (sample_q <= cfg_i.amplitude), "sample above peak")

endmodule

`default_nettype wire
